>>> src/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg: shared types and codes for the deadline thread scheduler table
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam logic [2:0] ACT_ATTACH   = 3'd0;
    localparam logic [2:0] ACT_DETACH   = 3'd1;
    localparam logic [2:0] ACT_NICE     = 3'd2;
    localparam logic [2:0] ACT_WAIT     = 3'd3;
    localparam logic [2:0] ACT_NOTIFY   = 3'd4;
    localparam logic [2:0] ACT_DISPATCH = 3'd5;
    localparam logic [2:0] ACT_FINISH   = 3'd6;
    localparam logic [2:0] ACT_READ     = 3'd7;

    localparam logic [1:0] ST_STARTING = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_WAITING  = 2'd2;
    localparam logic [1:0] ST_STOPPED  = 2'd3;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NONE     = 2'd1;
    localparam logic [1:0] RES_EMPTY    = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now;
        logic [2:0]  slot;
        logic [31:0] endpoint_id;
        logic [7:0]  channel;
        logic [31:0] attribute;
        logic [31:0] event_value;
        logic [31:0] amount;
        logic        no_deadline;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  chosen_slot;
        logic [31:0] sleep_ticks;
        logic [1:0]  slot_state;
        logic [31:0] slot_attribute;
        logic [31:0] slot_value;
        logic [3:0]  woken_count;
    } result_t;

endpackage

>>> src/dts_if.sv
// ----------------------------------------------------------------------------
// dts_item_if / dts_result_if: valid/ready channels
// ----------------------------------------------------------------------------
interface dts_item_if;
    import dts_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dts_result_if;
    import dts_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/deadline_task_scheduler_table.sv
// ----------------------------------------------------------------------------
// deadline_task_scheduler_table
// Thread slot table with earliest-deadline dispatch and event waits.
//
//   channel   dir   word
//   item      in    action, time, slot and wait/notify record
//   result    out   status, dispatch pick, read data, wake count
//
// Every action sweeps the slot memory: MAX_THREADS + 1 reads, the first slot
// read again at the end; S_LAST then settles the last read, S_WRITE fetches
// the addressed slot and S_OUT writes back, after S_IDLE has taken the word.
// Reset clears used bits and the current slot; memory content is undefined.
// A stalled result holds the block in its output state; one item in work.
// ----------------------------------------------------------------------------
module deadline_task_scheduler_table #(
    parameter int MAX_THREADS = 8,
    parameter int TIME_BITS   = 32
) (
    input logic clk,
    input logic rst_n,
    dts_item_if.sink     in_item,
    dts_result_if.source out_result
);
    import dts_pkg::*;

    localparam int SW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);

    typedef struct packed {
        logic [1:0]           status;
        logic [TIME_BITS-1:0] deadline;
        logic                 infinite;
        logic [TIME_BITS-1:0] nice;
        logic [31:0]          endpoint;
        logic [7:0]           channel;
        logic [31:0]          attribute;
        logic [31:0]          value;
    } entry_t;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    entry_t mem [MAX_THREADS];
    entry_t rd_reg;

    logic [2:0]             state_reg, state_next;
    logic [MAX_THREADS-1:0] used_reg, used_next;
    logic [SW-1:0]          cur_reg, cur_next;
    item_t                  item_reg;
    logic [SW:0]            rcnt_reg, rcnt_next;
    logic [SW-1:0]          raddr_reg, raddr_next;
    logic [SW-1:0]          pidx_reg, pidx_next;
    logic                   pval_reg, pval_next;
    logic                   we;
    logic [SW-1:0]          waddr;
    entry_t                 wdata;
    logic                   have_reg, have_next;
    logic                   start_reg, start_next;
    logic [SW-1:0]          cand_reg, cand_next;
    logic signed [TIME_BITS:0] cleft_reg, cleft_next;
    logic [CW-1:0]          woken_reg, woken_next;
    result_t                res_reg, res_next;
    logic                   ovalid_reg, ovalid_next;

    logic [TIME_BITS-1:0]   now_t, amt_t;
    logic                   sel_ok;
    logic [SW-1:0]          sel;
    logic signed [TIME_BITS:0] left;
    logic                   match;
    logic [SW-1:0]          nxt;
    logic                   nxt_ok;
    logic [SW:0]            widx;

    assign now_t  = item_reg.now[TIME_BITS-1:0];
    assign amt_t  = item_reg.amount[TIME_BITS-1:0];
    assign sel_ok = ({29'd0, item_reg.slot} < 32'(MAX_THREADS));
    assign sel    = SW'(item_reg.slot);
    assign left   = rd_reg.infinite ? '0
                  : $signed({1'b0, rd_reg.deadline}) - $signed({1'b0, now_t});
    assign match  = (rd_reg.endpoint == item_reg.endpoint_id)
                  && (rd_reg.channel == item_reg.channel)
                  && ((rd_reg.attribute == '0) || (rd_reg.attribute == item_reg.attribute));

    always_comb
    begin
        nxt    = '0;
        nxt_ok = 1'b0;
        widx   = '0;
        for (int k = MAX_THREADS; k >= 1; k--)
        begin
            widx = (SW+1)'(sel) + (SW+1)'(k);
            if (widx >= (SW+1)'(MAX_THREADS))
            begin
                widx = widx - (SW+1)'(MAX_THREADS);
            end
            if (used_reg[widx[SW-1:0]])
            begin
                nxt    = widx[SW-1:0];
                nxt_ok = 1'b1;
            end
        end
    end

    assign in_item.ready    = (state_reg == S_IDLE);
    assign out_result.valid = ovalid_reg;
    assign out_result.data  = res_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        cur_next    = cur_reg;
        rcnt_next   = rcnt_reg;
        raddr_next  = raddr_reg;
        pidx_next   = pidx_reg;
        pval_next   = 1'b0;
        have_next   = have_reg;
        start_next  = start_reg;
        cand_next   = cand_reg;
        cleft_next  = cleft_reg;
        woken_next  = woken_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = pidx_reg;
        wdata       = rd_reg;
        if (out_result.ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_item.valid)
                begin
                    woken_next = '0;
                    have_next  = 1'b0;
                    start_next = 1'b0;
                    rcnt_next  = '0;
                    if (in_item.data.action == ACT_DISPATCH)
                    begin
                        raddr_next = cur_reg;
                        cand_next  = cur_reg;
                    end
                    else
                    begin
                        raddr_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN, S_LAST:
            begin
                if (pval_reg && used_reg[pidx_reg])
                begin
                    case (item_reg.action)
                        ACT_NOTIFY:
                        begin
                            if (match && rcnt_reg != (SW+1)'(MAX_THREADS + 1))
                            begin
                                we              = 1'b1;
                                wdata.attribute = item_reg.attribute;
                                wdata.value     = item_reg.event_value;
                                wdata.status    = ST_RUNNING;
                                woken_next      = woken_reg + CW'(1);
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            if (!start_reg)
                            begin
                                if (!have_reg)
                                begin
                                    have_next  = 1'b1;
                                    cand_next  = pidx_reg;
                                    cleft_next = left;
                                end
                                if (rd_reg.status == ST_STARTING
                                    && rcnt_reg != (SW+1)'(1))
                                begin
                                    start_next = 1'b1;
                                    cand_next  = pidx_reg;
                                end
                                else if (rcnt_reg != (SW+1)'(1) && have_reg
                                         && (rd_reg.status == ST_RUNNING
                                             || rd_reg.status == ST_WAITING)
                                         && left < cleft_reg)
                                begin
                                    cand_next  = pidx_reg;
                                    cleft_next = left;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (state_reg == S_LAST)
                begin
                    state_next = S_WRITE;
                    raddr_next = (item_reg.action == ACT_DISPATCH) ? cand_next : sel;
                end
                else
                begin
                    pidx_next  = raddr_reg;
                    pval_next  = 1'b1;
                    raddr_next = (raddr_reg == SW'(MAX_THREADS - 1)) ? '0
                               : raddr_reg + SW'(1);
                    rcnt_next  = rcnt_reg + 1'b1;
                    if (rcnt_reg == (SW+1)'(MAX_THREADS))
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_WRITE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_result.ready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                    waddr       = raddr_reg;
                    res_next    = '0;
                    case (item_reg.action)
                        ACT_ATTACH:
                        begin
                            if (sel_ok)
                            begin
                                we                = 1'b1;
                                used_next[sel]    = 1'b1;
                                wdata.status      = ST_STARTING;
                                wdata.infinite    = item_reg.no_deadline;
                                wdata.deadline    = item_reg.no_deadline ? '0 : now_t + amt_t;
                                wdata.nice        = '0;
                                wdata.endpoint    = '0;
                                wdata.channel     = '0;
                                wdata.attribute   = '0;
                                wdata.value       = '0;
                            end
                            else
                            begin
                                res_next.status = RES_EMPTY;
                            end
                        end
                        ACT_NOTIFY:
                        begin
                            if (used_reg == '0)
                            begin
                                res_next.status = RES_NONE;
                            end
                            else
                            begin
                                res_next.woken_count = (woken_reg > CW'(15)) ? 4'd15
                                                     : 4'(woken_reg);
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            if (used_reg == '0)
                            begin
                                res_next.status = RES_NONE;
                            end
                            else
                            begin
                                we                   = 1'b1;
                                wdata.status         = ST_RUNNING;
                                cur_next             = cand_reg;
                                res_next.chosen_slot = 3'(cand_reg);
                                if (!start_reg && cleft_reg > 0)
                                begin
                                    res_next.sleep_ticks = 32'(cleft_reg[TIME_BITS-1:0]);
                                end
                            end
                        end
                        default:
                        begin
                            if (!sel_ok || !used_reg[sel])
                            begin
                                res_next.status = RES_EMPTY;
                            end
                            else
                            begin
                                case (item_reg.action)
                                    ACT_DETACH: used_next[sel] = 1'b0;
                                    ACT_NICE:
                                    begin
                                        we         = 1'b1;
                                        wdata.nice = amt_t;
                                    end
                                    ACT_WAIT:
                                    begin
                                        we              = 1'b1;
                                        wdata.status    = ST_WAITING;
                                        wdata.infinite  = 1'b0;
                                        wdata.deadline  = now_t + amt_t;
                                        wdata.endpoint  = item_reg.endpoint_id;
                                        wdata.channel   = item_reg.channel;
                                        wdata.attribute = item_reg.attribute;
                                        wdata.value     = '0;
                                    end
                                    ACT_FINISH:
                                    begin
                                        we             = 1'b1;
                                        wdata.infinite = 1'b0;
                                        wdata.deadline = now_t + rd_reg.nice;
                                        if (nxt_ok)
                                        begin
                                            cur_next = nxt;
                                        end
                                    end
                                    default:
                                    begin
                                        res_next.slot_state     = rd_reg.status;
                                        res_next.slot_attribute = rd_reg.attribute;
                                        res_next.slot_value     = rd_reg.value;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            cur_reg    <= '0;
            ovalid_reg <= 1'b0;
            pval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            cur_reg    <= cur_next;
            ovalid_reg <= ovalid_next;
            pval_reg   <= pval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            item_reg <= in_item.data;
        end
        rcnt_reg  <= rcnt_next;
        raddr_reg <= raddr_next;
        pidx_reg  <= pidx_next;
        have_reg  <= have_next;
        start_reg <= start_next;
        cand_reg  <= cand_next;
        cleft_reg <= cleft_next;
        woken_reg <= woken_next;
        res_reg   <= res_next;
    end

endmodule
